FILE: rtl/mlfqs_priority_load_unit_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef MLFQS_PRIORITY_LOAD_UNIT_ASSERT_SVH
`define MLFQS_PRIORITY_LOAD_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define MPLU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MPLU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/mplu_pkg.sv
`timescale 1ns / 1ps

package mplu_pkg;

   // Fixed-point format and field widths
   localparam int FRAC_BITS   = 14;
   localparam int FIX_W       = 32;
   localparam int CPU_W       = 32;
   localparam int NICE_W      = 6;
   localparam int COUNT_W     = 8;
   localparam int PRIO_W      = 8;
   localparam int OPCODE_W    = 3;
   localparam int LOAD_NOW_W  = 31;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = PRIO_W;

   localparam logic [PRIO_W-1:0] HIGHEST_RESET = PRIO_W'(63);
   localparam logic [PRIO_W-1:0] LOWEST_RESET  = PRIO_W'(0);

   localparam logic [CSR_INDEX_W-1:0] CSR_HIGHEST = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_LOWEST  = CSR_INDEX_W'(1);

   // Scheduler constants
   localparam longint ONE          = longint'(1) <<< FRAC_BITS;
   localparam longint HALF         = ONE / 2;
   localparam longint LOAD_K       = (59 * ONE) / 60;
   localparam longint LOAD_STEP    = ONE / 60;
   localparam longint REPORT_SCALE = 100;
   localparam int     CPU_DIV_SH   = 2;            // recent cpu / 4
   localparam longint CPU_DIV_BIAS = (longint'(1) <<< CPU_DIV_SH) - 1;

   // Datapath widths
   localparam int DIV_W  = FIX_W + 1 + FRAC_BITS;  // 2L*F and shifted divisor
   localparam int MA_W   = FIX_W + 1;
   localparam int MB_W   = FRAC_BITS + 2;
   localparam int PROD_W = MA_W + MB_W;
   localparam int STEP_W = COUNT_W + 1 + FRAC_BITS;
   localparam int CNT_W  = $clog2(FRAC_BITS);

   typedef enum logic [OPCODE_W-1:0] {
      OP_PRIORITY      = 3'd0,
      OP_DECAY_CPU     = 3'd1,
      OP_UPDATE_LOAD   = 3'd2,
      OP_INCREMENT_CPU = 3'd3,
      OP_REPORT_CPU    = 3'd4,
      OP_REPORT_LOAD   = 3'd5
   } opcode_type;

   typedef struct packed {
      opcode_type                opcode;
      logic signed [CPU_W-1:0]   cpu_usage;
      logic signed [NICE_W-1:0]  niceness;
      logic [COUNT_W-1:0]        ready_count;
      logic                      running_idle;
      logic [PRIO_W-1:0]         old_priority;
   } req_payload_type;

   typedef struct packed {
      logic signed [FIX_W-1:0]   result_value;
      logic [LOAD_NOW_W-1:0]     load_now;
   } rsp_payload_type;

   typedef struct packed {
      logic start;      // capture item, load divider
      logic div_step;   // one quotient bit
      logic mul_step;   // register product
      logic finish;     // form result, commit load, fill output register
   } dp_cmd_type;

   typedef struct packed {
      logic op_decay;
   } dp_status_type;

   // Divide by F truncating toward zero
   function automatic logic signed [PROD_W-1:0] trunc_frac(
      input logic signed [PROD_W-1:0] x);
      logic signed [PROD_W-1:0] bias;
      bias = x[PROD_W-1] ? PROD_W'(ONE - 1) : '0;
      return (x + bias) >>> FRAC_BITS;
   endfunction

   // Divide by F rounding to nearest, halves away from zero
   function automatic logic signed [PROD_W-1:0] round_frac(
      input logic signed [PROD_W-1:0] x);
      logic signed [PROD_W-1:0] bias;
      bias = x[PROD_W-1] ? PROD_W'(HALF - 1) : PROD_W'(HALF);
      return (x + bias) >>> FRAC_BITS;
   endfunction

endpackage

FILE: rtl/mplu_if.sv
`timescale 1ns / 1ps

interface mplu_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [mplu_pkg::OPCODE_W-1:0]         opcode;
   logic signed [mplu_pkg::CPU_W-1:0]     cpu_usage;
   logic signed [mplu_pkg::NICE_W-1:0]    niceness;
   logic [mplu_pkg::COUNT_W-1:0]          ready_count;
   logic                                  running_idle;
   logic [mplu_pkg::PRIO_W-1:0]           old_priority;

   modport source (output valid, opcode, cpu_usage, niceness, ready_count, running_idle,
                   old_priority, input ready);
   modport sink (input valid, opcode, cpu_usage, niceness, ready_count, running_idle,
                 old_priority, output ready);
endinterface

interface mplu_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [mplu_pkg::FIX_W-1:0]     result_value;
   logic [mplu_pkg::LOAD_NOW_W-1:0]       load_now;

   modport source (output valid, result_value, load_now, input ready);
   modport sink (input valid, result_value, load_now, output ready);
endinterface

interface mplu_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [mplu_pkg::CSR_INDEX_W-1:0]      index;
   logic [mplu_pkg::CSR_DATA_W-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/mplu_ctrl.sv
`timescale 1ns / 1ps

module mplu_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   input  mplu_pkg::dp_status_type status,
   output mplu_pkg::dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE     = 4'b0001,
      ST_DIVIDE   = 4'b0010,
      ST_MULTIPLY = 4'b0100,
      ST_FINISH   = 4'b1000
   } state_type;

   localparam logic [mplu_pkg::CNT_W-1:0] LAST_BIT = mplu_pkg::CNT_W'(mplu_pkg::FRAC_BITS - 1);

   state_type                    state_ff, state_in;
   logic [mplu_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.start    = (state_ff == ST_IDLE) && req_valid;
      cmd.div_step = (state_ff == ST_DIVIDE) && status.op_decay;
      cmd.mul_step = (state_ff == ST_MULTIPLY);
      cmd.finish   = (state_ff == ST_FINISH) && out_free;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_valid) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            // only the decay opcode needs the quotient
            if (!status.op_decay || cnt_ff == LAST_BIT) begin
               state_in = ST_MULTIPLY;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_MULTIPLY: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/mplu_dp.sv
`timescale 1ns / 1ps

module mplu_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  mplu_pkg::dp_cmd_type                cmd,
   output mplu_pkg::dp_status_type             status,
   input  mplu_pkg::req_payload_type           req_data,
   input  logic                                csr_we,
   input  logic [mplu_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mplu_pkg::CSR_DATA_W-1:0]     csr_data,
   output mplu_pkg::rsp_payload_type           rsp_data
);

   localparam int FB     = mplu_pkg::FRAC_BITS;
   localparam int FIX_W  = mplu_pkg::FIX_W;
   localparam int DIV_W  = mplu_pkg::DIV_W;
   localparam int MA_W   = mplu_pkg::MA_W;
   localparam int MB_W   = mplu_pkg::MB_W;
   localparam int PROD_W = mplu_pkg::PROD_W;
   localparam int STEP_W = mplu_pkg::STEP_W;

   mplu_pkg::req_payload_type        item_ff, item_in;
   logic [mplu_pkg::PRIO_W-1:0]      hi_ff, hi_in, lo_ff, lo_in;
   logic signed [FIX_W-1:0]          load_ff, load_in;
   logic [DIV_W-1:0]                 rem_ff, rem_in, dsh_ff, dsh_in, den;
   logic [FB-1:0]                    quo_ff, quo_in;
   logic signed [PROD_W-1:0]         product_ff, product_in;
   logic [STEP_W-1:0]                step_ff, step_in;
   mplu_pkg::rsp_payload_type        rsp_ff, rsp_in;

   logic signed [MA_W-1:0]           mul_a;
   logic signed [MB_W-1:0]           mul_b;
   logic signed [PROD_W-1:0]         mul_full;
   logic signed [PROD_W-1:0]         cpu_ext, cpu_q, nice2_term, hi_term, prio_x;
   logic signed [PROD_W-1:0]         rnd, trn, lo_ext, hi_ext, decay_sum, load_next;
   logic [mplu_pkg::COUNT_W:0]       run_count;
   logic signed [FIX_W-1:0]          result;

   assign status.op_decay = (item_ff.opcode == mplu_pkg::OP_DECAY_CPU);
   assign rsp_data        = rsp_ff;

   // Configuration registers
   always_comb begin
      hi_in = hi_ff;
      lo_in = lo_ff;
      if (csr_we) begin
         unique case (csr_index)
            mplu_pkg::CSR_HIGHEST: hi_in = csr_data;
            mplu_pkg::CSR_LOWEST:  lo_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   assign item_in = cmd.start ? req_data : item_ff;

   // Restoring divider for c = 2L*F / (2L+F). Load never goes negative, so the
   // quotient is below F and FRAC_BITS quotient bits suffice.
   assign den = (DIV_W'(load_ff[FIX_W-2:0]) << 1) + DIV_W'(mplu_pkg::ONE);

   always_comb begin
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      quo_in = quo_ff;
      if (cmd.start) begin
         rem_in = DIV_W'(load_ff[FIX_W-2:0]) << (FB + 1);
         dsh_in = den << (FB - 1);
         quo_in = '0;
      end else if (cmd.div_step) begin
         dsh_in = dsh_ff >> 1;
         if (rem_ff >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff;
            quo_in = {quo_ff[FB-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[FB-2:0], 1'b0};
         end
      end
   end

   // Priority argument: hi*F - (cpu/4 + 2*nice*F)
   always_comb begin
      cpu_ext    = PROD_W'(item_ff.cpu_usage);
      cpu_q      = (cpu_ext + (cpu_ext[PROD_W-1] ? PROD_W'(mplu_pkg::CPU_DIV_BIAS)
                                                 : PROD_W'(0)))
                   >>> mplu_pkg::CPU_DIV_SH;
      nice2_term = PROD_W'(item_ff.niceness) <<< (FB + 1);
      hi_term    = PROD_W'(hi_ff) <<< FB;
      prio_x     = hi_term - (cpu_q + nice2_term);
   end

   // Shared multiplier operands
   always_comb begin
      mul_a = MA_W'(item_ff.cpu_usage);
      mul_b = MB_W'(mplu_pkg::REPORT_SCALE);
      case (item_ff.opcode) inside
         mplu_pkg::OP_DECAY_CPU: begin
            mul_a = MA_W'(item_ff.cpu_usage);
            mul_b = MB_W'(quo_ff);
         end
         mplu_pkg::OP_UPDATE_LOAD: begin
            mul_a = MA_W'(load_ff);
            mul_b = MB_W'(mplu_pkg::LOAD_K);
         end
         mplu_pkg::OP_REPORT_LOAD: begin
            mul_a = MA_W'(load_ff);
            mul_b = MB_W'(mplu_pkg::REPORT_SCALE);
         end
         default: begin
         end
      endcase
      mul_full = mul_a * mul_b;
   end

   assign run_count = {1'b0, item_ff.ready_count} + {{mplu_pkg::COUNT_W{1'b0}},
                                                     !item_ff.running_idle};

   always_comb begin
      product_in = product_ff;
      step_in    = step_ff;
      if (cmd.mul_step) begin
         product_in = (item_ff.opcode == mplu_pkg::OP_PRIORITY) ? prio_x : mul_full;
         step_in    = STEP_W'(run_count) * STEP_W'(mplu_pkg::LOAD_STEP);
      end
   end

   // Result formation
   always_comb begin
      rnd       = mplu_pkg::round_frac(product_ff);
      trn       = mplu_pkg::trunc_frac(product_ff);
      lo_ext    = PROD_W'(lo_ff);
      hi_ext    = PROD_W'(hi_ff);
      decay_sum = trn + (PROD_W'(item_ff.niceness) <<< FB);
      load_next = trn + $signed(PROD_W'(step_ff));
      result    = '0;
      case (item_ff.opcode) inside
         mplu_pkg::OP_PRIORITY: begin
            if (item_ff.running_idle) begin
               result = FIX_W'(item_ff.old_priority);
            end else if (rnd < lo_ext) begin
               result = FIX_W'(lo_ff);
            end else if (rnd > hi_ext) begin
               result = FIX_W'(hi_ff);
            end else begin
               result = rnd[FIX_W-1:0];
            end
         end
         mplu_pkg::OP_DECAY_CPU: result = decay_sum[FIX_W-1:0];
         mplu_pkg::OP_UPDATE_LOAD: result = load_next[FIX_W-1:0];
         mplu_pkg::OP_INCREMENT_CPU: begin
            result = item_ff.running_idle ? item_ff.cpu_usage
                                          : item_ff.cpu_usage + FIX_W'(mplu_pkg::ONE);
         end
         mplu_pkg::OP_REPORT_CPU, mplu_pkg::OP_REPORT_LOAD: result = rnd[FIX_W-1:0];
         default: result = '0;
      endcase
   end

   always_comb begin
      load_in = load_ff;
      rsp_in  = rsp_ff;
      if (cmd.finish) begin
         if (item_ff.opcode == mplu_pkg::OP_UPDATE_LOAD) begin
            load_in = load_next[FIX_W-1:0];
         end
         rsp_in.result_value = result;
         rsp_in.load_now     = (item_ff.opcode == mplu_pkg::OP_UPDATE_LOAD)
                               ? load_next[mplu_pkg::LOAD_NOW_W-1:0]
                               : load_ff[mplu_pkg::LOAD_NOW_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hi_ff   <= mplu_pkg::HIGHEST_RESET;
         lo_ff   <= mplu_pkg::LOWEST_RESET;
         load_ff <= '0;
      end else begin
         hi_ff   <= hi_in;
         lo_ff   <= lo_in;
         load_ff <= load_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      rem_ff     <= rem_in;
      dsh_ff     <= dsh_in;
      quo_ff     <= quo_in;
      product_ff <= product_in;
      step_ff    <= step_in;
      rsp_ff     <= rsp_in;
   end

endmodule

FILE: rtl/mlfqs_priority_load_unit.sv
`timescale 1ns / 1ps

// Channel   Dir  Payload                                                  Moves when
// req_bus   in   opcode cpu_usage niceness ready_count running_idle        valid & ready
//                old_priority
// rsp_bus   out  result_value load_now                                  valid & ready
// csr_bus   in   index data (0 highest_priority, 1 lowest_priority)       valid & ready
//
// Steps: a decay item runs the one-bit-per-cycle restoring divider for FRAC_BITS
// quotient bits, then the shared multiplier, then the result; every other opcode
// skips the divider steps and goes through operand setup, shared multiplier, result.
// One item is worked on at a time; req_ready returns as soon as the result sits in
// the output register, so the next transfer may come while that result still waits.
// Reset (synchronous, active high) clears the load average, restores the priority
// limits to 63 and 0, and empties the output register; no clearing pass is needed.
// csr_bus is always ready.

module mlfqs_priority_load_unit (
   input  logic       clock,
   input  logic       reset,
   mplu_req_if.sink   req_bus,
   mplu_rsp_if.source rsp_bus,
   mplu_csr_if.sink   csr_bus
);

   mplu_pkg::dp_cmd_type      cmd;
   mplu_pkg::dp_status_type   status;
   mplu_pkg::req_payload_type req_data;
   mplu_pkg::rsp_payload_type rsp_data;
   logic                      csr_we;

   // Pack the request fields for the datapath capture register
   always_comb begin
      req_data.opcode       = mplu_pkg::opcode_type'(req_bus.opcode);
      req_data.cpu_usage    = req_bus.cpu_usage;
      req_data.niceness     = req_bus.niceness;
      req_data.ready_count  = req_bus.ready_count;
      req_data.running_idle = req_bus.running_idle;
      req_data.old_priority = req_bus.old_priority;
   end

   // Configuration writes never stall
   assign csr_bus.ready = 1'b1;
   assign csr_we        = csr_bus.valid && csr_bus.ready;

   mplu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .status    (status),
      .cmd       (cmd)
   );

   mplu_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_bus.index),
      .csr_data  (csr_bus.data),
      .rsp_data  (rsp_data)
   );

   // Drive the result channel from the output register
   assign rsp_bus.result_value = rsp_data.result_value;
   assign rsp_bus.load_now     = rsp_data.load_now;

endmodule

FILE: rtl/mplu_checker.sv
`timescale 1ns / 1ps
`include "mlfqs_priority_load_unit_assert.svh"

module mplu_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [mplu_pkg::FIX_W-1:0]     result_value,
   input logic [mplu_pkg::LOAD_NOW_W-1:0]       load_now
);

   // one item in flight: the input is closed right after a transfer
   `MPLU_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready, "input open right after a transfer")

   // a new result only appears after the unit was busy
   `MPLU_ASSERT_SAME(a_result_after_busy, clock, reset, $rose(rsp_valid), $past(!req_ready), "result appeared without work")

   // a waiting result holds
   `MPLU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(result_value) && $stable(load_now), "stalled result changed")

endmodule

bind mlfqs_priority_load_unit mplu_checker u_mplu_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .result_value (rsp_bus.result_value),
   .load_now     (rsp_bus.load_now)
);
